// File: src/multi_channel_watchdog_top_macros.svh
// ----------------------------------------------------------------------------
// multi_channel_watchdog_top_macros.svh
// assertion macros used by the watchdog top
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_WATCHDOG_TOP_MACROS_SVH
`define MULTI_CHANNEL_WATCHDOG_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define MCW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/mcw_pkg.sv
// ----------------------------------------------------------------------------
// mcw_pkg
// types and constants of the multi-channel watchdog
// ----------------------------------------------------------------------------
package mcw_pkg;

  localparam int TICK_W       = 32;
  localparam int FUNC_W       = 2;
  localparam int SLOT_IDX_W   = 3;
  localparam int NUM_SLOTS_DEF = 8;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADVANCE = 2'd0,
    FN_ARM     = 2'd1,
    FN_DISARM  = 2'd2,
    FN_RELOAD  = 2'd3
  } mcw_func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RANK,
    ST_SWEEP,
    ST_TAIL,
    ST_FINISH
  } mcw_state_t;

  // control from the sequencer to the slot evaluator
  typedef struct packed {
    logic arm_go;
    logic disarm_go;
    logic reload_go;
    logic clear_best;
    logic proc_vld;
  } mcw_ctrl_t;

endpackage

// File: src/mcw_if.sv
// ----------------------------------------------------------------------------
// mcw_if
// valid/ready stream interfaces for the watchdog command and result channels
// ----------------------------------------------------------------------------
interface mcw_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [2:0]  slot_index;
  logic [31:0] timeout_value;
  logic [31:0] tick_step;

  modport source (output valid, func, slot_index, timeout_value, tick_step,
                  input ready);
  modport sink   (input valid, func, slot_index, timeout_value, tick_step,
                  output ready);
endinterface

interface mcw_out_if;
  logic       valid;
  logic       ready;
  logic       ok;
  logic       expired_found;
  logic [2:0] expired_slot;

  modport source (output valid, ok, expired_found, expired_slot, input ready);
  modport sink   (input valid, ok, expired_found, expired_slot, output ready);
endinterface

// File: src/mcw_ram.sv
// ----------------------------------------------------------------------------
// mcw_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module mcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: src/mcw_slot_eval.sv
// ----------------------------------------------------------------------------
// mcw_slot_eval
// per-slot read-modify-write and expiry search during the table sweep
// ----------------------------------------------------------------------------
module mcw_slot_eval #(
  parameter int NUM_SLOTS = 8,
  localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
  localparam int RANK_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
  localparam int ENTRY_W = 2 * 32 + RANK_W
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mcw_pkg::mcw_ctrl_t   ctrl,
  input  logic [SLOT_W-1:0]    proc_idx,
  input  logic [SLOT_W-1:0]    target_idx,
  input  logic [RANK_W-1:0]    disarm_rank,
  input  logic [NUM_SLOTS-1:0] armed,
  input  logic [31:0]          tick_now,
  input  logic [31:0]          timeout_in,
  input  logic [ENTRY_W-1:0]   rd_data,
  output logic                 wr_en,
  output logic [SLOT_W-1:0]    wr_addr,
  output logic [ENTRY_W-1:0]   wr_data,
  output logic                 found,
  output logic [SLOT_W-1:0]    best_idx
);
  import mcw_pkg::*;

  logic [TICK_W-1:0] tmo_old, lr_old, tmo_new, lr_new, age;
  logic [RANK_W-1:0] rk_old, rk_new, best_rank_r;
  logic              is_tgt, slot_on, expired, take;
  logic              found_r;
  logic [SLOT_W-1:0] best_idx_r;

  assign tmo_old = rd_data[ENTRY_W-1 -: TICK_W];
  assign lr_old  = rd_data[RANK_W +: TICK_W];
  assign rk_old  = rd_data[RANK_W-1:0];
  assign is_tgt  = (proc_idx == target_idx);
  assign slot_on = armed[proc_idx];

  always_comb begin
    tmo_new = tmo_old;
    lr_new  = lr_old;
    rk_new  = rk_old;
    if (ctrl.arm_go) begin
      if (is_tgt) begin
        tmo_new = timeout_in;
        lr_new  = tick_now;
        rk_new  = '0;
      end else if (slot_on) begin
        rk_new = rk_old + RANK_W'(1);
      end
    end
    if (ctrl.disarm_go && !is_tgt && slot_on && (rk_old > disarm_rank)) begin
      rk_new = rk_old - RANK_W'(1);
    end
    if (ctrl.reload_go && is_tgt) begin
      lr_new = tick_now;
    end
  end

  // modular age against timeout, then keep the newest armed expired slot
  assign age     = tick_now - lr_new;
  assign expired = slot_on && (age >= tmo_new);
  assign take    = ctrl.proc_vld && expired && (!found_r || (rk_new < best_rank_r));

  assign wr_en   = ctrl.proc_vld;
  assign wr_addr = proc_idx;
  assign wr_data = {tmo_new, lr_new, rk_new};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (ctrl.clear_best) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear_best) begin
      best_idx_r  <= '0;
      best_rank_r <= '0;
    end else if (take) begin
      best_idx_r  <= proc_idx;
      best_rank_r <= rk_new;
    end
  end

  assign found    = found_r;
  assign best_idx = best_idx_r;

endmodule

// File: src/multi_channel_watchdog_top.sv
// ----------------------------------------------------------------------------
// multi_channel_watchdog_top
// table of watchdog slots on a shared wrapping tick counter
// ----------------------------------------------------------------------------
// usage: commands enter on in_chan (advance, arm, disarm, reload), one
// result per command leaves on out_chan with ok, expired_found and the
// expired slot that was armed most recently.
// timeout, last-reload time and arm rank of each slot live in one ram;
// armed flags and the tick counter are flops.
// every command is one sweep over the ram: a target read for the disarm
// rank, then one read-modify-write per slot with the expiry search folded
// in. the slots are taken one after another through the single read port
// of the slot ram.
// one command is in work at a time; in_chan.ready is high only when idle.
// the result register decouples the sides: a new command is taken while a
// result waits, and a finished sweep holds until the result register is free.
// reset clears the tick counter, the armed flags and the handshakes; ram
// contents need no clearing since a slot entry only counts while armed.
// ----------------------------------------------------------------------------
`include "multi_channel_watchdog_top_macros.svh"

module multi_channel_watchdog_top #(
  parameter int NUM_SLOTS = mcw_pkg::NUM_SLOTS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  mcw_in_if.sink   in_chan,
  mcw_out_if.source out_chan
);
  import mcw_pkg::*;

  localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int RANK_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int ENTRY_W = 2 * TICK_W + RANK_W;

  mcw_state_t state_r, state_nxt;

  logic [TICK_W-1:0]    tick_r;
  logic [NUM_SLOTS-1:0] armed_r;
  logic [TICK_W-1:0]    tmo_r;
  logic [SLOT_W-1:0]    tgt_r;
  logic [RANK_W-1:0]    rank_r;
  logic                 arm_go_r, disarm_go_r, reload_go_r, ok_r;
  logic [SLOT_W-1:0]    rd_idx_r;
  logic [SLOT_W-1:0]    proc_idx_r;
  logic                 proc_vld_r;

  logic                 out_valid_r, out_ok_r, out_found_r;
  logic [SLOT_IDX_W-1:0] out_slot_r;

  logic                 xfer, in_range, tgt_armed, arm_ok, disarm_ok, is_rw_cmd;
  logic                 load_out, sweep_last;
  mcw_func_t            func;
  logic [SLOT_W-1:0]    in_tgt;
  logic [SLOT_W-1:0]    rd_addr;
  logic                 ram_we;
  logic [SLOT_W-1:0]    ram_wr_addr;
  logic [ENTRY_W-1:0]   ram_wr_data, ram_rd_data;
  logic                 found;
  logic [SLOT_W-1:0]    best_idx;
  mcw_ctrl_t            ctrl;

  // command decode at the input transfer
  assign func      = mcw_func_t'(in_chan.func);
  assign xfer      = in_chan.valid && in_chan.ready;
  assign in_range  = (32'(in_chan.slot_index) < NUM_SLOTS);
  assign in_tgt    = in_range ? SLOT_W'(in_chan.slot_index) : '0;
  assign tgt_armed = in_range && armed_r[in_tgt];
  assign arm_ok    = (func == FN_ARM) && (in_chan.timeout_value != '0) && in_range
                     && !tgt_armed;
  assign disarm_ok = (func == FN_DISARM) && tgt_armed;
  assign is_rw_cmd = (func == FN_ARM) || (func == FN_DISARM);

  assign sweep_last = (rd_idx_r == SLOT_W'(NUM_SLOTS - 1));
  assign load_out   = (state_r == ST_FINISH) && (!out_valid_r || out_chan.ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_chan.valid) state_nxt = ST_RANK;
      ST_RANK:   state_nxt = ST_SWEEP;
      ST_SWEEP:  if (sweep_last) state_nxt = ST_TAIL;
      ST_TAIL:   state_nxt = ST_FINISH;
      ST_FINISH: if (load_out) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_chan.ready   = 1'b0;
    rd_addr         = '0;
    ctrl.arm_go     = arm_go_r;
    ctrl.disarm_go  = disarm_go_r;
    ctrl.reload_go  = reload_go_r;
    ctrl.clear_best = 1'b0;
    ctrl.proc_vld   = proc_vld_r;
    case (state_r)
      ST_IDLE: begin
        in_chan.ready = 1'b1;
        rd_addr       = in_tgt;
      end
      ST_RANK:  ctrl.clear_best = 1'b1;
      ST_SWEEP: rd_addr = rd_idx_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tick_r      <= '0;
      armed_r     <= '0;
      proc_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      proc_vld_r <= (state_r == ST_SWEEP);
      if (xfer) begin
        if (func == FN_ADVANCE) begin
          tick_r <= tick_r + in_chan.tick_step;
        end
        if (arm_ok) begin
          armed_r[in_tgt] <= 1'b1;
        end
        if (disarm_ok) begin
          armed_r[in_tgt] <= 1'b0;
        end
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      tmo_r       <= in_chan.timeout_value;
      tgt_r       <= in_tgt;
      arm_go_r    <= arm_ok;
      disarm_go_r <= disarm_ok;
      reload_go_r <= (func == FN_RELOAD) && in_range;
      ok_r        <= !is_rw_cmd || arm_ok || disarm_ok;
    end
    // rank of the target slot, read at the transfer
    if (state_r == ST_RANK) begin
      rank_r   <= ram_rd_data[RANK_W-1:0];
      rd_idx_r <= '0;
    end else if (state_r == ST_SWEEP) begin
      rd_idx_r <= rd_idx_r + SLOT_W'(1);
    end
    proc_idx_r <= rd_idx_r;
    if (load_out) begin
      out_ok_r    <= ok_r;
      out_found_r <= found;
      out_slot_r  <= found ? SLOT_IDX_W'(best_idx) : '0;
    end
  end

  mcw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (rd_addr),
    .rd_data (ram_rd_data)
  );

  mcw_slot_eval #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_slot_eval (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .proc_idx    (proc_idx_r),
    .target_idx  (tgt_r),
    .disarm_rank (rank_r),
    .armed       (armed_r),
    .tick_now    (tick_r),
    .timeout_in  (tmo_r),
    .rd_data     (ram_rd_data),
    .wr_en       (ram_we),
    .wr_addr     (ram_wr_addr),
    .wr_data     (ram_wr_data),
    .found       (found),
    .best_idx    (best_idx)
  );

  assign out_chan.valid         = out_valid_r;
  assign out_chan.ok            = out_ok_r;
  assign out_chan.expired_found = out_found_r;
  assign out_chan.expired_slot  = out_slot_r;

  `MCW_ASSERT_NOW(a_sweep_no_rw_clash, ram_we && (state_r == ST_SWEEP), ram_wr_addr != rd_addr, "slot ram read and write hit the same entry")
  `MCW_ASSERT_NOW(a_write_in_sweep, ram_we, (state_r == ST_SWEEP) || (state_r == ST_TAIL), "slot ram written outside the sweep")
  `MCW_ASSERT_NEXT(a_arm_sets_flag, xfer && arm_ok, $countones(armed_r) == $countones($past(armed_r)) + 1, "accepted arm did not add one armed slot")
  `MCW_ASSERT_NEXT(a_finish_holds, (state_r == ST_FINISH) && out_valid_r && !out_chan.ready, state_r == ST_FINISH, "finished sweep left while result register was busy")

endmodule

// File: bench/mcw_tb_pkg.sv
// ----------------------------------------------------------------------------
// mcw_tb_pkg
// shadow slot table and result checking for the watchdog bench
// ----------------------------------------------------------------------------
// keeps its own copy of the tick counter and the slot table, works out the
// result of every accepted command and compares it with the results that
// leave the block, in order.
// ----------------------------------------------------------------------------
package mcw_tb_pkg;
  import mcw_pkg::*;

  typedef struct packed {
    logic       ok;
    logic       expired_found;
    logic [2:0] expired_slot;
  } wd_result_t;

  class slot_table_model;
    bit [31:0]   tick;
    bit          armed     [NUM_SLOTS_DEF];
    bit [31:0]   timeout   [NUM_SLOTS_DEF];
    bit [31:0]   reload_at [NUM_SLOTS_DEF];
    int unsigned arm_age   [NUM_SLOTS_DEF];
    wd_result_t  expected_results[$];
    int unsigned mismatches;
    int unsigned results_checked;
    int unsigned refusals;
    int unsigned expiries;

    function new();
      tick = '0;
      foreach (armed[i]) begin
        armed[i]     = 1'b0;
        timeout[i]   = '0;
        reload_at[i] = '0;
        arm_age[i]   = 0;
      end
      mismatches      = 0;
      results_checked = 0;
      refusals        = 0;
      expiries        = 0;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function bit is_armed(int unsigned s);
      return armed[s];
    endfunction

    function void note_command(mcw_func_t fn, logic [2:0] s, logic [31:0] tmo,
                               logic [31:0] per);
      wd_result_t  r;
      bit [31:0]   elapsed;
      int unsigned best_age;
      r        = '0;
      r.ok     = 1'b1;
      best_age = 0;
      case (fn)
        FN_ADVANCE: begin
          tick = tick + per;
        end
        FN_ARM: begin
          if (tmo == '0 || armed[s]) begin
            r.ok = 1'b0;
          end else begin
            // every armed slot gets one step older
            foreach (armed[i]) if (armed[i]) arm_age[i]++;
            timeout[s]   = tmo;
            reload_at[s] = tick;
            arm_age[s]   = 0;
            armed[s]     = 1'b1;
          end
        end
        FN_DISARM: begin
          if (!armed[s]) begin
            r.ok = 1'b0;
          end else begin
            armed[s] = 1'b0;
            // close the gap left in the arm order
            foreach (armed[i]) if (armed[i] && arm_age[i] > arm_age[s]) arm_age[i]--;
          end
        end
        default: begin
          reload_at[s] = tick;
        end
      endcase
      foreach (armed[i]) begin
        elapsed = tick - reload_at[i];
        if (armed[i] && elapsed >= timeout[i]) begin
          if (!r.expired_found || arm_age[i] < best_age) begin
            r.expired_found = 1'b1;
            r.expired_slot  = 3'(i);
            best_age        = arm_age[i];
          end
        end
      end
      if (!r.ok) refusals++;
      if (r.expired_found) expiries++;
      expected_results.push_back(r);
    endfunction

    function void report_mismatch(string what);
      mismatches++;
      if (mismatches <= 10) $display("%0t ns: mismatch: %s", $time, what);
    endfunction

    function void check_result(logic ok, logic found, logic [2:0] s);
      wd_result_t exp_r;
      results_checked++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result ok=%0b found=%0b slot=%0d with none pending",
                                  ok, found, s));
        return;
      end
      exp_r = expected_results.pop_front();
      if (ok !== exp_r.ok)
        report_mismatch($sformatf("ok expected %0b actual %0b", exp_r.ok, ok));
      if (found !== exp_r.expired_found)
        report_mismatch($sformatf("expired_found expected %0b actual %0b",
                                  exp_r.expired_found, found));
      if (s !== exp_r.expired_slot)
        report_mismatch($sformatf("expired_slot expected %0d actual %0d",
                                  exp_r.expired_slot, s));
    endfunction
  endclass

endpackage

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the multi-channel watchdog
// ----------------------------------------------------------------------------
// a directed run through the refusal, wrap and arm-order cases is followed
// by random command streams under three idle mixes on both channels, with a
// long result hold-off and sender pauses; every result is checked against
// the shadow slot table.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mcw_pkg::*;
  import mcw_tb_pkg::*;

  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 40;
  localparam int PHASE_ITEMS     = 517;

  logic clk;
  logic rst_n;

  mcw_in_if  in_chan ();
  mcw_out_if out_chan ();

  multi_channel_watchdog_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  slot_table_model slot_table = new();

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned commands_sent = 0;
  int unsigned hold_left     = 0;
  int unsigned stall_cycles  = 0;
  bit          hold_req      = 1'b0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    rst_n                 = 1'b0;
    in_chan.valid         = 1'b0;
    in_chan.func          = '0;
    in_chan.slot_index    = '0;
    in_chan.timeout_value = '0;
    in_chan.tick_step     = '0;
    out_chan.ready        = 1'b0;
  end

  // result side: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_OFF_CYCLES;
      hold_req  = 1'b0;
    end
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      slot_table.check_result(out_chan.ok, out_chan.expired_found, out_chan.expired_slot);
  end

  // ends the run when no transfer happens on either side for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("no transfer for %0d cycles, %0d results still pending",
                 WATCHDOG_LIMIT, slot_table.pending());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_cmd(mcw_func_t fn, logic [2:0] s, logic [31:0] tmo,
                          logic [31:0] per);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.func          <= fn;
    in_chan.slot_index    <= s;
    in_chan.timeout_value <= tmo;
    in_chan.tick_step     <= per;
    do @(posedge clk); while (!in_chan.ready);
    slot_table.note_command(fn, s, tmo, per);
    commands_sent++;
    @(negedge clk);
  endtask

  task automatic wait_all_results();
    in_chan.valid <= 1'b0;
    @(negedge clk);
    while (slot_table.pending() != 0) @(negedge clk);
  endtask

  // mostly a slot in the wanted armed state, sometimes any slot
  function automatic logic [2:0] choose_slot(bit want_armed);
    int unsigned fits[$];
    for (int i = 0; i < NUM_SLOTS_DEF; i++)
      if (slot_table.is_armed(i) == want_armed) fits.push_back(i);
    if (fits.size() == 0 || $urandom_range(0, 99) < 15) return 3'($urandom_range(0, 7));
    return 3'(fits[$urandom_range(0, fits.size() - 1)]);
  endfunction

  task automatic send_random();
    int unsigned pick;
    mcw_func_t   fn;
    logic [2:0]  s;
    logic [31:0] tmo;
    logic [31:0] per;
    pick = $urandom_range(0, 99);
    s    = 3'($urandom_range(0, 7));
    case ($urandom_range(0, 9))
      0:       tmo = $urandom();
      1, 2:    tmo = $urandom_range(1, 4096);
      default: tmo = $urandom_range(1, 64);
    endcase
    case ($urandom_range(0, 19))
      0, 1, 2:    per = $urandom();
      3, 4, 5, 6: per = $urandom_range(0, 256);
      default:    per = $urandom_range(0, 16);
    endcase
    if (pick < 6) begin
      // noise: any command on any slot
      fn = mcw_func_t'($urandom_range(0, 3));
    end else begin
      if (pick < 40)      fn = FN_ADVANCE;
      else if (pick < 65) fn = FN_ARM;
      else if (pick < 80) fn = FN_DISARM;
      else                fn = FN_RELOAD;
      if (fn == FN_ARM) s = choose_slot(1'b0);
      else if (fn != FN_ADVANCE) s = choose_slot(1'b1);
    end
    send_cmd(fn, s, tmo, per);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: refusals, unarmed reload, wrap, exact timeout, arm order
    send_cmd(FN_ADVANCE, 3'd0, 32'h0, 32'h0);
    send_cmd(FN_ARM,     3'd0, 32'h0, 32'h0);
    send_cmd(FN_DISARM,  3'd3, 32'h0, 32'h0);
    send_cmd(FN_RELOAD,  3'd5, 32'h0, 32'h0);
    send_cmd(FN_ARM,     3'd0, 32'h1, 32'hFFFF_FFFF);
    send_cmd(FN_ARM,     3'd0, 32'h5, 32'h0);
    send_cmd(FN_ADVANCE, 3'd7, 32'hFFFF_FFFF, 32'h1);
    send_cmd(FN_ARM,     3'd7, 32'hFFFF_FFFF, 32'h0);
    send_cmd(FN_ARM,     3'd3, 32'h2, 32'h0);
    send_cmd(FN_ADVANCE, 3'd0, 32'h0, 32'h2);
    send_cmd(FN_RELOAD,  3'd3, 32'h0, 32'h0);
    send_cmd(FN_DISARM,  3'd7, 32'h0, 32'h0);
    send_cmd(FN_ADVANCE, 3'd0, 32'h0, 32'hFFFF_FFFF);
    send_cmd(FN_ARM,     3'd1, 32'h8000_0000, 32'h0);
    send_cmd(FN_ADVANCE, 3'd0, 32'h0, 32'h7FFF_FFFF);
    send_cmd(FN_ADVANCE, 3'd0, 32'h0, 32'h1);
    send_cmd(FN_DISARM,  3'd0, 32'h0, 32'h0);
    send_cmd(FN_DISARM,  3'd3, 32'h0, 32'h0);
    send_cmd(FN_DISARM,  3'd1, 32'h0, 32'h0);
    send_cmd(FN_ARM,     3'd2, 32'hFFFF_FFFF, 32'h0);
    send_cmd(FN_ADVANCE, 3'd0, 32'h0, 32'hFFFF_FFFE);
    send_cmd(FN_ADVANCE, 3'd0, 32'h0, 32'h1);
    send_cmd(FN_DISARM,  3'd2, 32'h0, 32'h0);
    send_cmd(FN_DISARM,  3'd2, 32'h0, 32'h0);
    wait_all_results();

    send_idle_pct = 28;
    recv_idle_pct = 62;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (n == PHASE_ITEMS / 2) wait_all_results();
      send_random();
    end
    wait_all_results();

    send_idle_pct = 62;
    recv_idle_pct = 28;
    for (int n = 0; n < PHASE_ITEMS; n++) send_random();
    wait_all_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      // results back up while commands keep coming
      if (n == 100) hold_req = 1'b1;
      send_random();
    end

    in_chan.valid <= 1'b0;
    while (slot_table.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d commands under three idle mixes with a long result stall",
             commands_sent);
    $display("%0d results checked: %0d refused, %0d reported an expired slot",
             slot_table.results_checked, slot_table.refusals, slot_table.expiries);
    if (slot_table.mismatches == 0 && slot_table.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", slot_table.mismatches,
               slot_table.pending());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
